### rtl/core/stpdrv_pkg.sv
// ----------------------------------------------------------------------------
// stpdrv_pkg: shared types and constants of the half-step stepper driver
// Command codes, calibration stages, half-step table and result record.
// ----------------------------------------------------------------------------
`default_nettype none

package stpdrv_pkg;

  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = COUNT_BITS + 2;
  localparam int REM_BITS   = 32;
  localparam int SPR_BITS   = 16;
  localparam int EIGHTHS_BITS = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [SPR_BITS-1:0] SPR_RESET = 16'd4096;

  // divide by three through a reciprocal multiply
  localparam int DIV3_SHIFT = SUM_BITS + 2;
  localparam int DIV3_MUL_W = DIV3_SHIFT - 1;
  localparam longint unsigned DIV3_MUL = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
  localparam int DIV3_PROD_W = SUM_BITS + DIV3_MUL_W;
  localparam int QUOT_W = (SUM_BITS > SPR_BITS) ? SUM_BITS : SPR_BITS;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_RUN    = 2'd1,
    CMD_REV    = 2'd2,
    CMD_CALIB  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CAL_IDLE = 3'd0,
    CAL_SEEK = 3'd1,
    CAL_INT1 = 3'd2,
    CAL_INT2 = 3'd3,
    CAL_INT3 = 3'd4
  } cal_stage_t;

  typedef struct packed {
    logic [3:0]          coil_pattern;
    logic                stepped;
    logic                busy_res;
    logic                calibrated;
    logic [SPR_BITS-1:0] revolution_steps;
  } res_t;

  function automatic logic [3:0] half_step(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'd1;
      3'd1:    pat = 4'd3;
      3'd2:    pat = 4'd2;
      3'd3:    pat = 4'd6;
      3'd4:    pat = 4'd4;
      3'd5:    pat = 4'd12;
      3'd6:    pat = 4'd8;
      3'd7:    pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### rtl/core/stpdrv_core.sv
// ----------------------------------------------------------------------------
// stpdrv_core: sequencer state and per-request update
// Holds phase, step count, calibration state; forms the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module stpdrv_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    req_acc,
  input  wire stpdrv_pkg::cmd_t                        req_cmd,
  input  wire logic signed [stpdrv_pkg::EIGHTHS_BITS-1:0] req_eighths,
  input  wire logic                                    req_edge,
  output stpdrv_pkg::res_t                             res
);

  logic [2:0]                          phase_r, phase_nxt;
  logic [stpdrv_pkg::REM_BITS-1:0]     rem_r, rem_nxt;
  logic [stpdrv_pkg::SPR_BITS-1:0]     spr_r, spr_nxt;
  logic                                cal_done_r, cal_done_nxt;
  stpdrv_pkg::cal_stage_t              stage_r, stage_nxt;
  logic [stpdrv_pkg::COUNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [stpdrv_pkg::SUM_BITS-1:0]     sum_r, sum_nxt;
  logic [3:0]                          coil_r, coil_nxt;
  logic                                stepped;
  logic                                busy;
  logic                                fwd;
  logic                                do_step;
  logic signed [29:0]                  run_prod;
  logic [stpdrv_pkg::DIV3_PROD_W-1:0]  div_prod;
  logic [stpdrv_pkg::QUOT_W-1:0]       quot;
  logic [stpdrv_pkg::SPR_BITS-1:0]     quot_sat;

  assign busy     = (rem_r != '0) || (stage_r != stpdrv_pkg::CAL_IDLE);
  assign run_prod = $signed({1'b0, spr_r[stpdrv_pkg::SPR_BITS-1:3]}) * req_eighths;
  assign div_prod = stpdrv_pkg::DIV3_PROD_W'(sum_r)
                  * stpdrv_pkg::DIV3_PROD_W'(stpdrv_pkg::DIV3_MUL);
  assign quot     = stpdrv_pkg::QUOT_W'(div_prod >> stpdrv_pkg::DIV3_SHIFT);
  assign quot_sat = (quot > stpdrv_pkg::QUOT_W'({stpdrv_pkg::SPR_BITS{1'b1}}))
                  ? {stpdrv_pkg::SPR_BITS{1'b1}} : stpdrv_pkg::SPR_BITS'(quot);

  always_comb begin
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    spr_nxt      = spr_r;
    cal_done_nxt = cal_done_r;
    stage_nxt    = stage_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    do_step      = 1'b0;
    fwd          = 1'b1;
    if (req_acc) begin
      if (req_cmd != stpdrv_pkg::CMD_TICK) begin
        if (!busy) begin
          case (req_cmd)
            stpdrv_pkg::CMD_RUN:   rem_nxt = stpdrv_pkg::REM_BITS'(run_prod);
            stpdrv_pkg::CMD_REV:   rem_nxt = stpdrv_pkg::REM_BITS'(spr_r);
            stpdrv_pkg::CMD_CALIB: begin
              stage_nxt = stpdrv_pkg::CAL_SEEK;
              cnt_nxt   = '0;
              sum_nxt   = '0;
            end
            default: rem_nxt = rem_r;
          endcase
        end
      end else if (stage_r != stpdrv_pkg::CAL_IDLE) begin
        if (req_edge) begin
          cnt_nxt = '0;
          case (stage_r)
            stpdrv_pkg::CAL_SEEK: stage_nxt = stpdrv_pkg::CAL_INT1;
            stpdrv_pkg::CAL_INT1: stage_nxt = stpdrv_pkg::CAL_INT2;
            stpdrv_pkg::CAL_INT2: stage_nxt = stpdrv_pkg::CAL_INT3;
            stpdrv_pkg::CAL_INT3: begin
              spr_nxt      = quot_sat;
              cal_done_nxt = 1'b1;
              stage_nxt    = stpdrv_pkg::CAL_IDLE;
              sum_nxt      = '0;
            end
            default: stage_nxt = stpdrv_pkg::CAL_IDLE;
          endcase
        end else begin
          do_step = 1'b1;
          // count only in the interval stages, saturating
          if ((stage_r != stpdrv_pkg::CAL_SEEK) && (cnt_r != '1)) begin
            cnt_nxt = cnt_r + 1'b1;
            sum_nxt = sum_r + 1'b1;
          end
        end
      end else if (rem_r != '0) begin
        do_step = 1'b1;
        fwd     = ~rem_r[stpdrv_pkg::REM_BITS-1];
        rem_nxt = fwd ? (rem_r - 1'b1) : (rem_r + 1'b1);
      end
    end
    stepped  = do_step;
    coil_nxt = do_step ? stpdrv_pkg::half_step(phase_r) : coil_r;
    if (do_step) begin
      phase_nxt = fwd ? (phase_r + 3'd1) : (phase_r - 3'd1);
    end
  end

  always_comb begin
    res.coil_pattern     = coil_nxt;
    res.stepped          = stepped;
    res.busy_res         = (rem_nxt != '0) || (stage_nxt != stpdrv_pkg::CAL_IDLE);
    res.calibrated       = cal_done_nxt;
    res.revolution_steps = spr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      rem_r      <= '0;
      spr_r      <= stpdrv_pkg::SPR_RESET;
      cal_done_r <= 1'b0;
      stage_r    <= stpdrv_pkg::CAL_IDLE;
      cnt_r      <= '0;
      sum_r      <= '0;
      coil_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      rem_r      <= rem_nxt;
      spr_r      <= spr_nxt;
      cal_done_r <= cal_done_nxt;
      stage_r    <= stage_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      coil_r     <= coil_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/stpdrv_out.sv
// ----------------------------------------------------------------------------
// stpdrv_out: result register of the stepper driver
// Holds one result until taken; frees itself when the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module stpdrv_out (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  res_load,
  input  wire stpdrv_pkg::res_t                      res,
  output logic                                       load_ready,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [stpdrv_pkg::OUT_DATA_W-1:0]          out_tdata
);

  logic                      valid_r, valid_nxt;
  stpdrv_pkg::res_t          res_r;

  assign load_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, res_r.revolution_steps, res_r.calibrated, res_r.busy_res,
                       res_r.stepped, res_r.coil_pattern};

endmodule

`default_nettype wire

### rtl/core/stepper_half_step_calibrating_driver_top.sv
// ----------------------------------------------------------------------------
// stepper_half_step_calibrating_driver_top: half-step stepper sequencer
// Drives four coils through the half-step table and calibrates the step
// count of one revolution from an index sensor.
//
// Input stream: one request per command or tick; tuser carries the command
// (tick, run eighths, run one revolution, calibrate), tdata the signed
// eighths and the index edge flag. Output stream: one result per request
// with coil pattern, step flag, busy, calibrated and steps per revolution.
// The result is registered, valid the cycle after; a request is taken in every
// cycle while the result register is free or being emptied, so the rate is
// one request per cycle, set by the single state update per request.
// A stalled receiver holds the result register and backpressures the input.
// Reset clears the coils, the phase, the step count and calibration, and
// sets steps per revolution to 4096; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_half_step_calibrating_driver_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [15:0] run_eighths, [16] opto_edge, [23:17] zero
  input  wire logic [stpdrv_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] command
  input  wire logic [1:0]                          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [3:0] coil_pattern, [4] stepped, [5] busy_res, [6] calibrated,
  // [22:7] revolution_steps, [23] zero
  output logic [stpdrv_pkg::OUT_DATA_W-1:0]        out_tdata
);

  logic              in_acc;
  stpdrv_pkg::res_t  res;

  assign in_acc = in_tvalid && in_tready;

  stpdrv_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_acc     (in_acc),
    .req_cmd     (stpdrv_pkg::cmd_t'(in_tuser)),
    .req_eighths ($signed(in_tdata[stpdrv_pkg::EIGHTHS_BITS-1:0])),
    .req_edge    (in_tdata[stpdrv_pkg::EIGHTHS_BITS]),
    .res         (res)
  );

  stpdrv_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (in_acc),
    .res        (res),
    .load_ready (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted request produced no result");

  a_step_drives_coils: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[4]) |-> (out_tdata[3:0] != 4'd0))
    else $error("step reported with all coils off");

  a_calibrated_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.calibrated) |=> u_out.res_r.calibrated)
    else $error("calibrated flag lost");
`endif

endmodule

`default_nettype wire

### dv/tb_stepper_half_step_calibrating_driver_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_half_step_calibrating_driver_top: half-step stepper driver bench
// Walks a short directed table (reset state, zero runs, commands while busy,
// a full calibration, extreme eighths), then random calibrations, runs and
// idle noise.
// Each result is checked field by field against table values or an in-bench
// model of the sequencer, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------

module tb_stepper_half_step_calibrating_driver_top;
  import stpdrv_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1900;

  localparam logic [3:0] COIL_SEQ [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  localparam res_t IDLE_AT_RESET = '{4'd0, 1'b0, 1'b0, 1'b0, SPR_RESET};
  localparam res_t BUSY_AT_RESET = '{4'd0, 1'b0, 1'b1, 1'b0, SPR_RESET};

  typedef struct {
    cmd_t        cmd;
    logic [15:0] eighths;
    logic        opto;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = CMD_TICK;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  stepper_half_step_calibrating_driver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // model of the sequencer
  logic [2:0]  drv_phase;
  logic [31:0] drv_remaining;
  logic [15:0] drv_spr;
  logic        drv_cal_done;
  cal_stage_t  drv_stage;
  logic [15:0] drv_interval;
  logic [17:0] drv_sum;
  logic [3:0]  drv_coils;

  res_t coil_reports_due [$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   stimulus_count = 0;
  bit   no_idle_run = 1'b0;
  stim_row_t directed_rows [0:20];

  function automatic logic driver_busy();
    return drv_remaining != 32'd0 || drv_stage != CAL_IDLE;
  endfunction

  function automatic void drive_coils(input logic forward);
    drv_coils = COIL_SEQ[drv_phase];
    drv_phase = forward ? drv_phase + 3'd1 : drv_phase - 3'd1;
  endfunction

  function automatic res_t advance_coils(input cmd_t cmd, input logic [15:0] eighths,
                                         input logic opto);
    longint     prod;
    logic [17:0] quot;
    logic       forward;
    res_t       r;
    r = '0;
    if (cmd != CMD_TICK) begin
      if (!driver_busy()) begin
        case (cmd)
          CMD_RUN: begin
            prod = longint'(drv_spr >> 3) * longint'($signed(eighths));
            drv_remaining = prod[31:0];
          end
          CMD_REV: drv_remaining = {16'd0, drv_spr};
          default: begin
            drv_stage = CAL_SEEK;
            drv_interval = '0;
            drv_sum = '0;
          end
        endcase
      end
    end else if (drv_stage != CAL_IDLE) begin
      if (opto) begin
        if (drv_stage == CAL_SEEK) begin
          drv_stage = CAL_INT1;
          drv_interval = '0;
        end else begin
          drv_sum = drv_sum + drv_interval;
          drv_interval = '0;
          if (drv_stage == CAL_INT3) begin
            quot = drv_sum / 18'd3;
            drv_spr = (quot > 18'd65535) ? 16'hFFFF : quot[15:0];
            drv_cal_done = 1'b1;
            drv_stage = CAL_IDLE;
            drv_sum = '0;
          end else begin
            drv_stage = cal_stage_t'(drv_stage + 3'd1);
          end
        end
      end else begin
        drive_coils(1'b1);
        r.stepped = 1'b1;
        if (drv_stage != CAL_SEEK && drv_interval != 16'hFFFF)
          drv_interval = drv_interval + 16'd1;
      end
    end else if (drv_remaining != 32'd0) begin
      forward = !drv_remaining[31];
      drive_coils(forward);
      r.stepped = 1'b1;
      drv_remaining = forward ? drv_remaining - 32'd1 : drv_remaining + 32'd1;
    end
    r.coil_pattern = drv_coils;
    r.busy_res = driver_busy();
    r.calibrated = drv_cal_done;
    r.revolution_steps = drv_spr;
    return r;
  endfunction

  function automatic int draw_wait();
    if (no_idle_run)
      return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40)
      $display("%0t mismatch %s: got %0d, want %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic send_request(input cmd_t cmd, input logic [15:0] eighths, input logic opto,
                              input bit typed, input res_t want);
    int   gap;
    res_t predicted;
    gap = draw_wait();
    if ($urandom_range(0, 63) == 0)
      no_idle_run = !no_idle_run;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, opto, eighths};
    do @(posedge clk); while (!in_tready);
    predicted = advance_coils(cmd, eighths, opto);
    coil_reports_due.push_back(typed ? want : predicted);
  endtask

  task automatic offer(input cmd_t cmd, input logic [15:0] eighths, input logic opto);
    send_request(cmd, eighths, opto, 1'b0, '0);
  endtask

  // tick while busy, now and then preceded by a command that must be dropped
  task automatic busy_tick(input logic opto);
    if ($urandom_range(0, 15) == 0)
      offer(cmd_t'($urandom_range(1, 3)), 16'($urandom), 1'($urandom));
    offer(CMD_TICK, 16'($urandom), opto);
    stimulus_count++;
  endtask

  initial begin : stimulus
    int k;
    int len;
    int unit;
    int lim;
    int e;
    drv_phase = '0;
    drv_remaining = '0;
    drv_spr = SPR_RESET;
    drv_cal_done = 1'b0;
    drv_stage = CAL_IDLE;
    drv_interval = '0;
    drv_sum = '0;
    drv_coils = '0;
    directed_rows = '{
      '{CMD_TICK,  16'h0000, 1'b0, 1'b1, IDLE_AT_RESET},
      '{CMD_TICK,  16'hFFFF, 1'b1, 1'b1, IDLE_AT_RESET},
      '{CMD_RUN,   16'h0000, 1'b1, 1'b1, IDLE_AT_RESET},
      '{CMD_CALIB, 16'h0000, 1'b0, 1'b1, BUSY_AT_RESET},
      '{CMD_REV,   16'h0000, 1'b1, 1'b1, BUSY_AT_RESET},
      '{CMD_TICK,  16'h0000, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b1, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b1, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b1, 1'b0, '0},
      '{CMD_RUN,   16'h7FFF, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b1, 1'b0, '0},
      '{CMD_RUN,   16'h7FFF, 1'b0, 1'b0, '0},
      '{CMD_RUN,   16'h8000, 1'b1, 1'b0, '0},
      '{CMD_REV,   16'h0000, 1'b0, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b1, 1'b0, '0},
      '{CMD_TICK,  16'h0000, 1'b0, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].eighths, directed_rows[i].opto,
                   directed_rows[i].typed, directed_rows[i].want);

    while (stimulus_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          offer(CMD_CALIB, 16'($urandom), 1'($urandom));
          stimulus_count++;
          repeat ($urandom_range(0, 3)) busy_tick(1'b0);
          busy_tick(1'b1);
          for (k = 0; k < 3; k++) begin
            if ($urandom_range(0, 7) == 0)
              len = 0;
            else if ($urandom_range(0, 15) == 0)
              len = $urandom_range(100, 300);
            else
              len = $urandom_range(1, 40);
            repeat (len) busy_tick(1'b0);
            busy_tick(1'b1);
          end
        end
        2: begin
          offer(CMD_CALIB, 16'($urandom), 1'($urandom));
          stimulus_count++;
          while (driver_busy()) busy_tick($urandom_range(0, 5) == 0);
        end
        3, 4, 5, 6: begin
          unit = int'(drv_spr >> 3);
          if (unit == 0) begin
            e = int'(16'($urandom));
          end else begin
            lim = 300 / unit;
            if (lim < 1)
              lim = 1;
            e = int'($urandom_range(0, 2 * lim)) - lim;
          end
          offer(CMD_RUN, 16'(e), 1'($urandom));
          stimulus_count++;
          while (driver_busy()) busy_tick(1'($urandom));
        end
        7: begin
          if (drv_spr <= 16'd600) begin
            offer(CMD_REV, 16'($urandom), 1'($urandom));
            stimulus_count++;
            while (driver_busy()) busy_tick(1'($urandom));
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            offer(CMD_TICK, 16'($urandom), 1'($urandom));
            stimulus_count++;
          end
        end
      endcase
    end

    in_tvalid <= 1'b0;
    while (coil_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : receiver
    int stall;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      // hold off long enough to fill the block and stall its input
      if (taken == 300)
        stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.coil_pattern     = out_tdata[3:0];
      got.stepped          = out_tdata[4];
      got.busy_res         = out_tdata[5];
      got.calibrated       = out_tdata[6];
      got.revolution_steps = out_tdata[22:7];
      if (coil_reports_due.size() == 0) begin
        report_mismatch("result with no request", out_tdata, 0);
      end else begin
        want = coil_reports_due.pop_front();
        if (got.coil_pattern != want.coil_pattern)
          report_mismatch("coil_pattern", got.coil_pattern, want.coil_pattern);
        if (got.stepped != want.stepped)
          report_mismatch("stepped", got.stepped, want.stepped);
        if (got.busy_res != want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.calibrated != want.calibrated)
          report_mismatch("calibrated", got.calibrated, want.calibrated);
        if (got.revolution_steps != want.revolution_steps)
          report_mismatch("revolution_steps", got.revolution_steps, want.revolution_steps);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### files.f
rtl/core/stpdrv_pkg.sv
rtl/core/stpdrv_core.sv
rtl/core/stpdrv_out.sv
rtl/core/stepper_half_step_calibrating_driver_top.sv
dv/tb_stepper_half_step_calibrating_driver_top.sv
